### rtl/core/png_chunk_walker_assert.svh
// assertion macros for the png chunk walker checker
// expects clk and rst_n in the scope of each use
`ifndef PNG_CHUNK_WALKER_ASSERT_SVH
`define PNG_CHUNK_WALKER_ASSERT_SVH

// same-cycle implication
`define PCW_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pcw_pkg.sv
// types and constants shared by the png chunk walker modules
// no dependencies
package pcw_pkg;

    typedef enum logic [2:0] {
        PH_SIG,
        PH_LEN,
        PH_TYPE,
        PH_DATA,
        PH_CRC,
        PH_DONE
    } phase_t;

    localparam logic [3:0] EV_SIG_OK       = 4'd0;
    localparam logic [3:0] EV_SIG_BAD      = 4'd1;
    localparam logic [3:0] EV_IHDR_OK      = 4'd2;
    localparam logic [3:0] EV_IHDR_MISSING = 4'd3;
    localparam logic [3:0] EV_IDAT_FOUND   = 4'd4;
    localparam logic [3:0] EV_IEND_OK      = 4'd5;
    localparam logic [3:0] EV_NO_IDAT      = 4'd6;
    localparam logic [3:0] EV_NO_IEND      = 4'd7;
    localparam logic [3:0] EV_SUCCESS      = 4'd8;

    localparam int SIG_SIZE   = 8;
    localparam int FIELD_SIZE = 4;

    localparam logic [2:0] SIG_LAST   = 3'(SIG_SIZE - 1);
    localparam logic [2:0] FIELD_LAST = 3'(FIELD_SIZE - 1);

    localparam logic [7:0] SIG_BYTES [SIG_SIZE] = '{
        8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10
    };

    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    // results caused by one byte; the second result never carries chunk fields
    typedef struct packed {
        logic [3:0]  code0;
        logic [3:0]  code1;
        logic        two;
        logic [31:0] offset;
        logic [31:0] length;
        logic [31:0] crc;
    } entry_t;

endpackage

### rtl/core/pcw_byte_if.sv
// byte request channel of the png chunk walker
// no dependencies
interface pcw_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_file;

    modport source (output valid, output byte_value, output end_of_file, input ready);
    modport sink (input valid, input byte_value, input end_of_file, output ready);

endinterface

### rtl/core/pcw_event_if.sv
// event request channel of the png chunk walker
// no dependencies
interface pcw_event_if;

    logic        valid;
    logic        ready;
    logic [3:0]  event_code;
    logic [31:0] chunk_offset;
    logic [31:0] chunk_length;
    logic [31:0] chunk_crc;
    logic        last_result;

    modport source (
        output valid, output event_code, output chunk_offset, output chunk_length,
        output chunk_crc, output last_result, input ready
    );
    modport sink (
        input valid, input event_code, input chunk_offset, input chunk_length,
        input chunk_crc, input last_result, output ready
    );

endinterface

### rtl/core/pcw_front.sv
// front end: takes bytes, walks signature and chunk framing, classifies results
// depends on pcw_pkg and pcw_byte_if
module pcw_front (
    input  logic            clk,
    input  logic            rst_n,
    pcw_byte_if.sink        stream,
    output logic            push,
    output pcw_pkg::entry_t push_entry,
    input  logic            full
);

    pcw_pkg::phase_t phase_reg, phase_next, phase_step;
    logic [2:0]  byte_index_reg, byte_index_next;
    logic [31:0] file_offset_reg, file_offset_next;
    logic        seen_idat_reg, seen_idat_next;
    logic        first_chunk_reg, first_chunk_next;
    logic [31:0] skip_reg, skip_next;
    logic [31:0] chunk_start_reg, chunk_start_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] type_reg, type_next;
    logic [31:0] crc_reg, crc_next;

    logic        accept;
    logic [7:0]  b;
    logic        eof;
    logic        sig_match;
    logic        field_last;
    logic [31:0] skip_dec;
    logic [31:0] crc_shifted;
    logic        crc_end;
    logic        is_ihdr, is_idat, is_iend;
    logic        have0;
    logic [3:0]  code0;
    logic        iend_pair;
    logic        verdict;
    logic        first_after, seen_after;
    logic        eof_extra;
    logic [3:0]  eof_code;

    assign stream.ready = !full;
    assign accept       = stream.valid && !full;
    assign b            = stream.byte_value;
    assign eof          = stream.end_of_file;

    // classify the current byte
    always_comb
    begin
        sig_match   = (b == pcw_pkg::SIG_BYTES[byte_index_reg]);
        field_last  = (byte_index_reg == pcw_pkg::FIELD_LAST);
        skip_dec    = skip_reg - 32'd1;
        crc_shifted = {crc_reg[23:0], b};
        crc_end     = (phase_reg == pcw_pkg::PH_CRC) && field_last;
        is_ihdr     = (type_reg == pcw_pkg::TYPE_IHDR);
        is_idat     = (type_reg == pcw_pkg::TYPE_IDAT);
        is_iend     = (type_reg == pcw_pkg::TYPE_IEND);
        have0       = 1'b0;
        code0       = pcw_pkg::EV_SIG_OK;
        iend_pair   = 1'b0;
        verdict     = 1'b0;
        case (phase_reg)
            pcw_pkg::PH_SIG:
            begin
                if (!sig_match)
                begin
                    have0   = 1'b1;
                    code0   = pcw_pkg::EV_SIG_BAD;
                    verdict = 1'b1;
                end
                else if (byte_index_reg == pcw_pkg::SIG_LAST)
                begin
                    have0 = 1'b1;
                    code0 = pcw_pkg::EV_SIG_OK;
                end
            end
            pcw_pkg::PH_CRC:
            begin
                if (field_last)
                begin
                    if (first_chunk_reg)
                    begin
                        have0   = 1'b1;
                        code0   = is_ihdr ? pcw_pkg::EV_IHDR_OK : pcw_pkg::EV_IHDR_MISSING;
                        verdict = !is_ihdr;
                    end
                    else if (is_idat)
                    begin
                        have0 = 1'b1;
                        code0 = pcw_pkg::EV_IDAT_FOUND;
                    end
                    else if (is_iend)
                    begin
                        have0     = 1'b1;
                        verdict   = 1'b1;
                        iend_pair = seen_idat_reg;
                        code0     = seen_idat_reg ? pcw_pkg::EV_IEND_OK : pcw_pkg::EV_NO_IDAT;
                    end
                end
            end
            default:
            begin
            end
        endcase
        first_after = first_chunk_reg && !(crc_end && is_ihdr);
        seen_after  = seen_idat_reg || (crc_end && !first_chunk_reg && is_idat);
    end

    // phase next state
    always_comb
    begin
        phase_step = phase_reg;
        case (phase_reg)
            pcw_pkg::PH_SIG:
            begin
                if (sig_match && (byte_index_reg == pcw_pkg::SIG_LAST))
                    phase_step = pcw_pkg::PH_LEN;
            end
            pcw_pkg::PH_LEN:
            begin
                if (field_last)
                    phase_step = pcw_pkg::PH_TYPE;
            end
            pcw_pkg::PH_TYPE:
            begin
                if (field_last)
                    phase_step = (length_reg == 32'd0) ? pcw_pkg::PH_CRC : pcw_pkg::PH_DATA;
            end
            pcw_pkg::PH_DATA:
            begin
                if (skip_dec == 32'd0)
                    phase_step = pcw_pkg::PH_CRC;
            end
            pcw_pkg::PH_CRC:
            begin
                if (field_last)
                    phase_step = pcw_pkg::PH_LEN;
            end
            default:
            begin
                phase_step = phase_reg;
            end
        endcase
        phase_next = phase_reg;
        if (accept)
        begin
            if (eof)
                phase_next = pcw_pkg::PH_SIG;
            else if (verdict)
                phase_next = pcw_pkg::PH_DONE;
            else
                phase_next = phase_step;
        end
    end

    // counters and shift registers
    always_comb
    begin
        byte_index_next  = byte_index_reg;
        file_offset_next = file_offset_reg;
        seen_idat_next   = seen_idat_reg;
        first_chunk_next = first_chunk_reg;
        skip_next        = skip_reg;
        chunk_start_next = chunk_start_reg;
        length_next      = length_reg;
        type_next        = type_reg;
        crc_next         = crc_reg;
        if (accept)
        begin
            case (phase_reg)
                pcw_pkg::PH_SIG:
                begin
                    if (sig_match)
                        byte_index_next = (byte_index_reg == pcw_pkg::SIG_LAST) ? 3'd0
                                                                 : byte_index_reg + 3'd1;
                end
                pcw_pkg::PH_LEN:
                begin
                    if (byte_index_reg == 3'd0)
                        chunk_start_next = file_offset_reg;
                    length_next     = {length_reg[23:0], b};
                    byte_index_next = field_last ? 3'd0 : byte_index_reg + 3'd1;
                end
                pcw_pkg::PH_TYPE:
                begin
                    type_next       = {type_reg[23:0], b};
                    byte_index_next = field_last ? 3'd0 : byte_index_reg + 3'd1;
                    if (field_last)
                        skip_next = length_reg;
                end
                pcw_pkg::PH_DATA:
                begin
                    skip_next = skip_dec;
                end
                pcw_pkg::PH_CRC:
                begin
                    crc_next        = crc_shifted;
                    byte_index_next = field_last ? 3'd0 : byte_index_reg + 3'd1;
                end
                default:
                begin
                end
            endcase
            seen_idat_next   = seen_after;
            first_chunk_next = first_after;
            file_offset_next = file_offset_reg + 32'd1;
            if (eof)
            begin
                byte_index_next  = 3'd0;
                file_offset_next = 32'd0;
                seen_idat_next   = 1'b0;
                first_chunk_next = 1'b1;
            end
        end
    end

    // queue entry
    always_comb
    begin
        eof_extra = eof && !verdict && (phase_step != pcw_pkg::PH_DONE);
        if (phase_step == pcw_pkg::PH_SIG)
            eof_code = pcw_pkg::EV_SIG_BAD;
        else if (first_after)
            eof_code = pcw_pkg::EV_IHDR_MISSING;
        else if (seen_after)
            eof_code = pcw_pkg::EV_NO_IEND;
        else
            eof_code = pcw_pkg::EV_NO_IDAT;

        push              = accept && (have0 || eof_extra);
        push_entry.code0  = have0 ? code0 : eof_code;
        push_entry.code1  = iend_pair ? pcw_pkg::EV_SUCCESS : eof_code;
        push_entry.two    = have0 && (iend_pair || eof_extra);
        push_entry.offset = 32'd0;
        push_entry.length = 32'd0;
        push_entry.crc    = 32'd0;
        if (have0 && (code0 == pcw_pkg::EV_IDAT_FOUND))
        begin
            push_entry.offset = chunk_start_reg;
            push_entry.length = length_reg;
            push_entry.crc    = crc_shifted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= pcw_pkg::PH_SIG;
            byte_index_reg  <= 3'd0;
            file_offset_reg <= 32'd0;
            seen_idat_reg   <= 1'b0;
            first_chunk_reg <= 1'b1;
        end
        else
        begin
            phase_reg       <= phase_next;
            byte_index_reg  <= byte_index_next;
            file_offset_reg <= file_offset_next;
            seen_idat_reg   <= seen_idat_next;
            first_chunk_reg <= first_chunk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        skip_reg        <= skip_next;
        chunk_start_reg <= chunk_start_next;
        length_reg      <= length_next;
        type_reg        <= type_next;
        crc_reg         <= crc_next;
    end

endmodule

### rtl/core/pcw_queue.sv
// short queue of classified results between front and back
// depends on pcw_pkg
module pcw_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pcw_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output pcw_pkg::entry_t head,
    output logic            head_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pcw_pkg::entry_t slots [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_entry;
    end

endmodule

### rtl/core/pcw_emit.sv
// back end: unpacks queued entries into single event requests
// depends on pcw_pkg and pcw_event_if
module pcw_emit (
    input  logic            clk,
    input  logic            rst_n,
    input  pcw_pkg::entry_t head,
    input  logic            head_valid,
    output logic            pop,
    pcw_event_if.source     events
);

    logic        valid_reg, valid_next;
    logic        sec_pending_reg, sec_pending_next;
    logic [3:0]  sec_code_reg, sec_code_next;
    logic [3:0]  code_reg, code_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] crc_reg, crc_next;
    logic        last_reg, last_next;
    logic        load;

    assign load = !valid_reg || events.ready;
    assign pop  = load && !sec_pending_reg && head_valid;

    always_comb
    begin
        valid_next       = valid_reg;
        sec_pending_next = sec_pending_reg;
        sec_code_next    = sec_code_reg;
        code_next        = code_reg;
        offset_next      = offset_reg;
        length_next      = length_reg;
        crc_next         = crc_reg;
        last_next        = last_reg;
        if (load)
        begin
            if (sec_pending_reg)
            begin
                valid_next       = 1'b1;
                sec_pending_next = 1'b0;
                code_next        = sec_code_reg;
                offset_next      = 32'd0;
                length_next      = 32'd0;
                crc_next         = 32'd0;
                last_next        = 1'b1;
            end
            else if (head_valid)
            begin
                valid_next       = 1'b1;
                sec_pending_next = head.two;
                sec_code_next    = head.code1;
                code_next        = head.code0;
                offset_next      = head.offset;
                length_next      = head.length;
                crc_next         = head.crc;
                last_next        = !head.two;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= 1'b0;
            sec_pending_reg <= 1'b0;
        end
        else
        begin
            valid_reg       <= valid_next;
            sec_pending_reg <= sec_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sec_code_reg <= sec_code_next;
        code_reg     <= code_next;
        offset_reg   <= offset_next;
        length_reg   <= length_next;
        crc_reg      <= crc_next;
        last_reg     <= last_next;
    end

    assign events.valid        = valid_reg;
    assign events.event_code   = code_reg;
    assign events.chunk_offset = offset_reg;
    assign events.chunk_length = length_reg;
    assign events.chunk_crc    = crc_reg;
    assign events.last_result  = last_reg;

endmodule

### rtl/core/png_chunk_walker.sv
// top level of the png chunk walker: front end, result queue, back end
// depends on pcw_pkg, pcw_byte_if, pcw_event_if, pcw_front, pcw_queue, pcw_emit
//
// channel  dir  payload                                                 per request
// stream   in   byte_value[7:0], end_of_file                            one file byte
// events   out  event_code[3:0], chunk_offset, chunk_length, chunk_crc,  one event
//               last_result
//
// one byte per cycle; a byte's results enter the queue in the same cycle
// events leave one per cycle from a registered output while events.ready is high
// stream.ready drops only while the QUEUE_DEPTH-entry queue is full
// asynchronous active-low reset returns the walker to the signature phase
module png_chunk_walker #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    pcw_byte_if.sink    stream,
    pcw_event_if.source events
);

    logic            push;
    pcw_pkg::entry_t push_entry;
    logic            full;
    logic            pop;
    pcw_pkg::entry_t head;
    logic            head_valid;

    pcw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .push       (push),
        .push_entry (push_entry),
        .full       (full)
    );

    pcw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    pcw_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .events     (events)
    );

endmodule

### rtl/core/pcw_checker.sv
// port-level checks on the png chunk walker event channel, bound to the top level
// depends on pcw_pkg and png_chunk_walker_assert.svh
`include "png_chunk_walker_assert.svh"

module pcw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  event_code,
    input logic [31:0] chunk_offset,
    input logic [31:0] chunk_length,
    input logic [31:0] chunk_crc,
    input logic        last_result
);

    logic         stalled;
    logic         non_idat;
    logic         is_success;
    logic         iend_taken;
    logic         fields_zero;
    logic [100:0] payload;

    assign stalled     = out_valid && !out_ready;
    assign non_idat    = out_valid && (event_code != pcw_pkg::EV_IDAT_FOUND);
    assign is_success  = out_valid && (event_code == pcw_pkg::EV_SUCCESS);
    assign iend_taken  = out_valid && out_ready && (event_code == pcw_pkg::EV_IEND_OK);
    assign fields_zero = (chunk_offset == 32'd0) && (chunk_length == 32'd0)
                         && (chunk_crc == 32'd0);
    assign payload     = {event_code, chunk_offset, chunk_length, chunk_crc, last_result};

    `PCW_ASSERT_NEXT(a_stall_hold, stalled, out_valid && $stable(payload), "stalled event changed")
    `PCW_ASSERT_IMPLY(a_fields_zero, non_idat, fields_zero, "non-idat event carries chunk fields")
    `PCW_ASSERT_IMPLY(a_success_last, is_success, last_result, "success not marked last")
    `PCW_ASSERT_NEXT(a_iend_then_success, iend_taken, is_success, "iend ok not followed by success")

endmodule

bind png_chunk_walker pcw_checker u_pcw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (events.valid),
    .out_ready    (events.ready),
    .event_code   (events.event_code),
    .chunk_offset (events.chunk_offset),
    .chunk_length (events.chunk_length),
    .chunk_crc    (events.chunk_crc),
    .last_result  (events.last_result)
);
